@@ hdl/ws2812_pixel_pulse_encoder_top_assert.svh @@
// Assertion macros shared by the pixel pulse encoder modules.
`ifndef WS2812_PIXEL_PULSE_ENCODER_TOP_ASSERT_SVH
`define WS2812_PIXEL_PULSE_ENCODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WPPE_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WPPE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/wppe_pkg.sv @@
// Shared constants and controller/datapath interface types for the pulse encoder.
package wppe_pkg;

  localparam int LED_COUNT_DEF   = 16;
  localparam int RESET_WORDS_DEF = 40;

  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 4 * CHAN_W;
  localparam int WORD_W    = 3 * CHAN_W;
  localparam int POS_W     = 10;
  localparam int BIT_CNT_W = 5;
  localparam int BITS_PER_PIXEL = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_BRIGHTNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RULE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_WIDTH         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_WIDTH        = 2'd3;

  localparam logic [CHAN_W-1:0] GLOBAL_BRIGHTNESS_RST = 8'd30;
  localparam logic              SCALE_RULE_RST        = 1'b0;
  localparam logic [CHAN_W-1:0] ONE_WIDTH_RST         = 8'd48;
  localparam logic [CHAN_W-1:0] ZERO_WIDTH_RST        = 8'd24;

  localparam logic SCALE_RULE_ALPHA  = 1'b0;
  localparam logic SCALE_RULE_GLOBAL = 1'b1;

  typedef struct packed {
    logic load;      // take buffered pixel, work out brightness factor
    logic scale;     // scale channels, advance LED position
    logic bit_step;  // one pixel word transferred
    logic gap_step;  // one reset word transferred
    logic in_gap;    // output currently shows reset words
  } wppe_cmd_t;

  typedef struct packed {
    logic buf_full;
    logic bit_done;
    logic gap_done;
    logic frame_end;
  } wppe_sts_t;

endpackage

@@ hdl/wppe_ctrl.sv @@
// Sequencer for the pulse encoder: load, scale, send bits, send reset gap.
`include "ws2812_pixel_pulse_encoder_top_assert.svh"

module wppe_ctrl
  import wppe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  wppe_sts_t sts,
  input  logic      out_tready,
  output logic      out_tvalid,
  output wppe_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_SCALE = 5'b00100,
    ST_BITS  = 5'b01000,
    ST_GAP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_xfer;

  assign out_tvalid = (state_r == ST_BITS) || (state_r == ST_GAP);
  assign out_xfer   = out_tvalid && out_tready;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_LOAD);
    cmd.scale    = (state_r == ST_SCALE);
    cmd.bit_step = (state_r == ST_BITS) && out_xfer;
    cmd.gap_step = (state_r == ST_GAP) && out_xfer;
    cmd.in_gap   = (state_r == ST_GAP);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.buf_full) state_nxt = ST_LOAD;
      end
      ST_LOAD:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_BITS;
      ST_BITS: begin
        if (out_xfer && sts.bit_done) begin
          if (sts.frame_end)     state_nxt = ST_GAP;
          else if (sts.buf_full) state_nxt = ST_LOAD;
          else                   state_nxt = ST_IDLE;
        end
      end
      ST_GAP: begin
        if (out_xfer && sts.gap_done) begin
          state_nxt = sts.buf_full ? ST_LOAD : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `WPPE_ASSERT_NOW(a_gap_needs_frame_end, clk, rst_n, state_r == ST_GAP, sts.frame_end, "reset gap outside frame end")
  `WPPE_ASSERT_NEXT(a_bits_hold_on_stall, clk, rst_n, (state_r == ST_BITS) && !out_tready, state_r == ST_BITS, "pixel word dropped under stall")

endmodule

@@ hdl/wppe_dpath.sv @@
// Datapath: input buffer, config registers, brightness scaling, bit shifter, counters.
`include "ws2812_pixel_pulse_encoder_top_assert.svh"

module wppe_dpath
  import wppe_pkg::*;
#(
  parameter int LED_COUNT   = LED_COUNT_DEF,
  parameter int RESET_WORDS = RESET_WORDS_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  wppe_cmd_t             cmd,
  output wppe_sts_t             sts,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int GAP_W = (RESET_WORDS > 1) ? $clog2(RESET_WORDS) : 1;

  // config registers
  logic [CHAN_W-1:0] gbright_r, one_w_r, zero_w_r;
  logic              rule_r;

  // input buffer
  logic [PIX_W-1:0]  buf_r;
  logic              buf_full_r, buf_full_nxt;

  // working pixel
  logic [CHAN_W-1:0] red_r, green_r, blue_r, k_r, k_nxt;
  logic              scl_r, scl_nxt;
  logic [WORD_W-1:0] word_r;
  logic [2*CHAN_W-1:0] k_prod, r_prod, g_prod, b_prod;
  logic [CHAN_W-1:0] r_s, g_s, b_s, a_in;

  logic [POS_W-1:0]     pos_r, pos_inc;
  logic                 fend_r, fend_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r;
  logic [GAP_W-1:0]     gap_cnt_r;
  logic                 bit_val, in_xfer;

  assign in_tready = !buf_full_r;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    buf_full_nxt = buf_full_r;
    if (in_xfer)       buf_full_nxt = 1'b1;
    else if (cmd.load) buf_full_nxt = 1'b0;
  end

  // brightness factor from buffered alpha and global brightness
  assign a_in   = buf_r[4*CHAN_W-1:3*CHAN_W];
  assign k_prod = (2*CHAN_W)'(a_in) * (2*CHAN_W)'(gbright_r);

  always_comb begin
    k_nxt   = gbright_r;
    scl_nxt = 1'b1;
    if (rule_r == SCALE_RULE_ALPHA) begin
      if (a_in != '0)           k_nxt = k_prod[2*CHAN_W-1:CHAN_W];
      else if (gbright_r == '0) scl_nxt = 1'b0;
    end else begin
      if (gbright_r == '0) begin
        k_nxt = a_in;
        if (a_in == '0) scl_nxt = 1'b0;
      end
    end
  end

  assign r_prod = (2*CHAN_W)'(red_r) * (2*CHAN_W)'(k_r);
  assign g_prod = (2*CHAN_W)'(green_r) * (2*CHAN_W)'(k_r);
  assign b_prod = (2*CHAN_W)'(blue_r) * (2*CHAN_W)'(k_r);
  assign r_s    = scl_r ? r_prod[2*CHAN_W-1:CHAN_W] : red_r;
  assign g_s    = scl_r ? g_prod[2*CHAN_W-1:CHAN_W] : green_r;
  assign b_s    = scl_r ? b_prod[2*CHAN_W-1:CHAN_W] : blue_r;

  assign pos_inc  = pos_r + POS_W'(1);
  assign fend_nxt = (pos_inc >= POS_W'(LED_COUNT)) || (pos_inc == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gbright_r  <= GLOBAL_BRIGHTNESS_RST;
      rule_r     <= SCALE_RULE_RST;
      one_w_r    <= ONE_WIDTH_RST;
      zero_w_r   <= ZERO_WIDTH_RST;
      buf_full_r <= 1'b0;
      pos_r      <= '0;
      fend_r     <= 1'b0;
      bit_cnt_r  <= '0;
      gap_cnt_r  <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_GLOBAL_BRIGHTNESS: gbright_r <= cfg_data;
          CFG_SCALE_RULE:        rule_r    <= cfg_data[0];
          CFG_ONE_WIDTH:         one_w_r   <= cfg_data;
          CFG_ZERO_WIDTH:        zero_w_r  <= cfg_data;
          default: ;
        endcase
      end
      buf_full_r <= buf_full_nxt;
      if (cmd.scale) begin
        pos_r     <= fend_nxt ? '0 : pos_inc;
        fend_r    <= fend_nxt;
        bit_cnt_r <= '0;
        gap_cnt_r <= '0;
      end
      if (cmd.bit_step) bit_cnt_r <= bit_cnt_r + BIT_CNT_W'(1);
      if (cmd.gap_step) gap_cnt_r <= gap_cnt_r + GAP_W'(1);
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) buf_r <= in_tdata;
    if (cmd.load) begin
      red_r   <= buf_r[CHAN_W-1:0];
      green_r <= buf_r[2*CHAN_W-1:CHAN_W];
      blue_r  <= buf_r[3*CHAN_W-1:2*CHAN_W];
      k_r     <= k_nxt;
      scl_r   <= scl_nxt;
    end
    if (cmd.scale)         word_r <= {g_s, r_s, b_s};
    else if (cmd.bit_step) word_r <= {word_r[WORD_W-2:0], 1'b0};
  end

  assign sts.buf_full  = buf_full_r;
  assign sts.bit_done  = (bit_cnt_r == BIT_CNT_W'(BITS_PER_PIXEL - 1));
  assign sts.gap_done  = (gap_cnt_r == GAP_W'(RESET_WORDS - 1));
  assign sts.frame_end = fend_r;

  // tdata: [7:0] pulse_width, [8] data_bit, rest zero
  assign bit_val = cmd.in_gap ? 1'b0 : word_r[WORD_W-1];
  always_comb begin
    out_tdata         = '0;
    out_tdata[8]      = bit_val;
    out_tdata[7:0]    = cmd.in_gap ? '0 : (bit_val ? one_w_r : zero_w_r);
  end
  assign out_tlast = cmd.in_gap ? sts.gap_done : (sts.bit_done && !fend_r);

  `WPPE_ASSERT_NOW(a_pos_in_range, clk, rst_n, 1'b1,
                   pos_r < POS_W'(LED_COUNT), "LED position out of range")
  `WPPE_ASSERT_NEXT(a_load_frees_buffer, clk, rst_n, cmd.load,
                    !buf_full_r, "buffer still full after load")

endmodule

@@ hdl/ws2812_pixel_pulse_encoder_top.sv @@
// Top level of the WS2812 pixel pulse encoder: controller plus datapath.
//
// Takes one pixel (red, green, blue, alpha) per input transfer, scales the colour
// channels by a brightness factor and sends the pixel as 24 pulse-width words in
// GRB order, MSB first: one_width for a one bit, zero_width for a zero bit.
// After the LED_COUNT-th pixel of a frame, RESET_WORDS zero words follow as the
// latch gap; tlast marks the final word caused by each pixel.
// Sequence: each pixel passes a load state (the alpha * global multiply), a
// scale state (the three channel multiplies) and then 24 word slots through the
// output, which hold under back-pressure; a pixel that closes a frame adds
// RESET_WORDS zero word slots.
// A one-pixel input buffer lets the next pixel transfer in while the current one
// is still going out. Configuration is taken in any cycle (cfg_ready tied high)
// and is meant to change only when the encoder is idle.
// Reset leaves global brightness 30, scale rule 0, one width 48, zero width 24
// and the LED position at 0.

module ws2812_pixel_pulse_encoder_top
  import wppe_pkg::*;
#(
  parameter int LED_COUNT   = LED_COUNT_DEF,   // LEDs per frame, 1..1023
  parameter int RESET_WORDS = RESET_WORDS_DEF  // zero words after a frame, at least 1
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  // pulse word output
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pulse_width[7:0], data_bit[8], zero[15:9]
  output logic                  out_tlast,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  wppe_cmd_t cmd;
  wppe_sts_t sts;

  // Registers are simple flops: a write transfer completes every cycle.
  assign cfg_ready = 1'b1;

  wppe_dpath #(
    .LED_COUNT   (LED_COUNT),
    .RESET_WORDS (RESET_WORDS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  wppe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

endmodule
